/* design/dmp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dmp_pkg;
   typedef enum logic [2:0] {
      PH_HEADER, PH_CODE, PH_LEN, PH_DATA, PH_SKIP, PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      K_NONE, K_SINGLE, K_BYTES, K_CLIENT, K_ADDR4, K_ARRAY4
   } kind_type;

   localparam logic [4:0] FC_OP      = 5'd0;
   localparam logic [4:0] FC_XID     = 5'd4;
   localparam logic [4:0] FC_SECS    = 5'd5;
   localparam logic [4:0] FC_FLAGS   = 5'd6;
   localparam logic [4:0] FC_CIADDR  = 5'd7;
   localparam logic [4:0] FC_YIADDR  = 5'd8;
   localparam logic [4:0] FC_GIADDR  = 5'd9;
   localparam logic [4:0] FC_CHADDR  = 5'd10;
   localparam logic [4:0] FC_SNAME   = 5'd11;
   localparam logic [4:0] FC_FILE    = 5'd12;
   localparam logic [4:0] FC_ERROR   = 5'd26;
   localparam logic [4:0] FC_LENGTH  = 5'd27;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_COOKIE  = 2'd1;
   localparam logic [1:0] ERR_SIZE    = 2'd2;
   localparam logic [1:0] ERR_UNKNOWN = 2'd3;

   localparam logic [7:0] HDR_LEN = 8'd236;
   localparam logic [7:0] TAG_PAD = 8'd0;
   localparam logic [7:0] TAG_END = 8'd255;

   typedef struct packed {
      logic [4:0]  code;
      logic [47:0] value;
      logic [7:0]  index;
      logic [1:0]  err;
      logic        last;
   } result_type;

   function automatic logic [7:0] cookie_byte(input logic [1:0] i);
      case (i)
         2'd0: cookie_byte = 8'd99;
         2'd1: cookie_byte = 8'd130;
         2'd2: cookie_byte = 8'd83;
         default: cookie_byte = 8'd99;
      endcase
   endfunction

   function automatic kind_type opt_kind(input logic [7:0] tag);
      case (tag)
         8'd53: opt_kind = K_SINGLE;
         8'd12, 8'd55: opt_kind = K_BYTES;
         8'd61: opt_kind = K_CLIENT;
         8'd50, 8'd1, 8'd54, 8'd58, 8'd59, 8'd51: opt_kind = K_ADDR4;
         8'd3, 8'd6, 8'd42: opt_kind = K_ARRAY4;
         default: opt_kind = K_NONE;
      endcase
   endfunction

   function automatic logic [4:0] opt_code(input logic [7:0] tag);
      case (tag)
         8'd53: opt_code = 5'd13;
         8'd12: opt_code = 5'd14;
         8'd55: opt_code = 5'd15;
         8'd61: opt_code = 5'd16;
         8'd50: opt_code = 5'd17;
         8'd1:  opt_code = 5'd18;
         8'd3:  opt_code = 5'd19;
         8'd6:  opt_code = 5'd20;
         8'd42: opt_code = 5'd21;
         8'd54: opt_code = 5'd22;
         8'd58: opt_code = 5'd23;
         8'd59: opt_code = 5'd24;
         8'd51: opt_code = 5'd25;
         default: opt_code = 5'd0;
      endcase
   endfunction
endpackage
`default_nettype wire

/* design/dmp_core.sv */
`timescale 1ns / 1ps
`default_nettype none
module dmp_core
   import dmp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] data_byte,
   input  wire logic       frame_start,
   output result_type      result,
   output logic            result_valid
);
   phase_type   phase_ff, phase_in;
   logic [7:0]  offset_ff, offset_in;
   logic [7:0]  tag_ff, tag_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic [47:0] acc_ff, acc_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] length_ff, length_in;
   logic        bad_ff, bad_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         offset_ff <= '0;
         tag_ff <= '0;
         remaining_ff <= '0;
         acc_ff <= '0;
         count_ff <= '0;
         length_ff <= 16'(HDR_LEN);
         bad_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         offset_ff <= offset_in;
         tag_ff <= tag_in;
         remaining_ff <= remaining_in;
         acc_ff <= acc_in;
         count_ff <= count_in;
         length_ff <= length_in;
         bad_ff <= bad_in;
      end
   end

   always_comb begin
      phase_type   ph;
      logic [7:0]  off, tag, rem, cnt, rem_dec;
      logic [47:0] acc, acc_sh;
      logic [15:0] len, len_inc;
      logic        bad, ok;
      kind_type    kind;
      logic [4:0]  code;
      ph = phase_ff; off = offset_ff; tag = tag_ff; rem = remaining_ff;
      acc = acc_ff; cnt = count_ff; len = length_ff; bad = bad_ff;
      if (frame_start) begin
         ph = PH_HEADER; off = '0; tag = '0; rem = '0; acc = '0; cnt = '0;
         len = 16'(HDR_LEN); bad = 1'b0;
      end
      acc_sh = {acc[39:0], data_byte};
      len_inc = (len == 16'hFFFF) ? len : len + 16'd1;
      rem_dec = rem - 8'd1;
      kind = opt_kind(tag);
      code = opt_code(tag);
      ok = 1'b1;
      phase_in = ph; offset_in = off; tag_in = tag; remaining_in = rem;
      acc_in = acc; count_in = cnt; length_in = len; bad_in = bad;
      result = '0;
      result_valid = 1'b0;
      case (ph)
         PH_HEADER: begin
            acc_in = acc_sh;
            offset_in = off + 8'd1;
            if (off >= HDR_LEN) begin
               length_in = len_inc;
               if (data_byte != cookie_byte(off[1:0])) bad_in = 1'b1;
               if (off >= HDR_LEN + 8'd3) begin
                  phase_in = PH_CODE;
                  if (bad_in) begin
                     result_valid = 1'b1;
                     result.code = FC_ERROR;
                     result.err = ERR_COOKIE;
                  end
               end
            end else begin
               result_valid = 1'b1;
               if (off == 8'd0) begin
                  result.code = FC_OP;
                  result.value = (data_byte == 8'd1) ? 48'd1 : 48'd2;
               end else if (off <= 8'd3) begin
                  result.code = off[4:0];
                  result.value = 48'(data_byte);
               end else if (off == 8'd7) begin
                  result.code = FC_XID; result.value = 48'(acc_sh[31:0]);
               end else if (off == 8'd9) begin
                  result.code = FC_SECS; result.value = 48'(acc_sh[15:0]);
               end else if (off == 8'd11) begin
                  result.code = FC_FLAGS; result.value = 48'(acc_sh[15:0]);
               end else if (off == 8'd15) begin
                  result.code = FC_CIADDR; result.value = 48'(acc_sh[31:0]);
               end else if (off == 8'd19) begin
                  result.code = FC_YIADDR; result.value = 48'(acc_sh[31:0]);
               end else if (off == 8'd27) begin
                  result.code = FC_GIADDR; result.value = 48'(acc_sh[31:0]);
               end else if (off == 8'd33) begin
                  result.code = FC_CHADDR; result.value = acc_sh;
               end else if (off >= 8'd44 && off < 8'd108) begin
                  result.code = FC_SNAME; result.value = 48'(data_byte);
                  result.index = off - 8'd44;
               end else if (off >= 8'd108) begin
                  result.code = FC_FILE; result.value = 48'(data_byte);
                  result.index = off - 8'd108;
               end else begin
                  result_valid = 1'b0;
               end
            end
         end
         PH_CODE: begin
            length_in = len_inc;
            if (data_byte == TAG_END) begin
               phase_in = PH_DONE;
               result_valid = 1'b1;
               result.code = FC_LENGTH;
               result.value = 48'(len_inc);
               result.last = 1'b1;
            end else if (data_byte != TAG_PAD) begin
               tag_in = data_byte;
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            length_in = len_inc;
            remaining_in = data_byte;
            count_in = '0;
            acc_in = '0;
            case (kind)
               K_SINGLE: ok = (data_byte == 8'd1);
               K_CLIENT: ok = (data_byte == 8'd7);
               K_ADDR4:  ok = (data_byte == 8'd4);
               K_ARRAY4: ok = (data_byte[1:0] == 2'd0);
               default:  ok = 1'b1;
            endcase
            if (kind == K_NONE || !ok) begin
               phase_in = (data_byte != 8'd0) ? PH_SKIP : PH_CODE;
               result_valid = 1'b1;
               result.code = FC_ERROR;
               result.value = 48'(tag);
               result.err = (kind == K_NONE) ? ERR_UNKNOWN : ERR_SIZE;
            end else begin
               phase_in = (data_byte != 8'd0) ? PH_DATA : PH_CODE;
            end
         end
         PH_DATA: begin
            length_in = len_inc;
            acc_in = acc_sh;
            count_in = cnt + 8'd1;
            remaining_in = rem_dec;
            if (rem_dec == 8'd0) phase_in = PH_CODE;
            result.code = code;
            case (kind)
               K_SINGLE: begin
                  result_valid = 1'b1;
                  result.value = 48'(data_byte);
               end
               K_BYTES: begin
                  result_valid = 1'b1;
                  result.value = 48'(data_byte);
                  result.index = cnt;
               end
               K_ADDR4: begin
                  result_valid = (rem_dec == 8'd0);
                  result.value = 48'(acc_sh[31:0]);
               end
               K_ARRAY4: begin
                  result_valid = (cnt[1:0] == 2'd3);
                  result.value = 48'(acc_sh[31:0]);
                  result.index = {2'b00, cnt[7:2]};
               end
               K_CLIENT: begin
                  if (cnt == 8'd0 && data_byte != 8'd1) begin
                     phase_in = (rem_dec != 8'd0) ? PH_SKIP : PH_CODE;
                     result_valid = 1'b1;
                     result.code = FC_ERROR;
                     result.value = 48'(tag);
                     result.err = ERR_SIZE;
                  end else begin
                     result_valid = (rem_dec == 8'd0);
                     result.value = acc_sh;
                  end
               end
               default: result_valid = 1'b0;
            endcase
         end
         PH_SKIP: begin
            length_in = len_inc;
            remaining_in = rem_dec;
            if (rem_dec == 8'd0) phase_in = PH_CODE;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

/* design/dhcp_message_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// byte-stream dhcp/bootp parser: one message byte per request, and a new request can be
// taken every cycle unless a result stalls on rsp_tready. the byte waits in an input
// register, the field decoder works on it combinationally and its result, if the byte
// yields one, goes into an output register when the decoder steps, and rsp_tvalid offers
// it from there. while a result waits for rsp_tready the decoder does not step, and
// req_tready drops once the input register is also full
module dhcp_message_parser
   import dmp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // data_byte
   input  wire logic        req_tuser,  // frame_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,  // field_value, element_index, zero fill
   output logic [6:0]       rsp_tuser,  // field_code, error_code
   output logic             rsp_tlast
);
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type result;
   logic       result_valid;
   logic       step;

   assign step = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (step) out_valid_ff <= result_valid;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_start_ff <= req_tuser;
      end
      if (step) out_ff <= result;
   end

   dmp_core u_core (
      .clock(clock), .reset(reset), .step(step),
      .data_byte(in_byte_ff), .frame_start(in_start_ff),
      .result(result), .result_valid(result_valid)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {8'd0, out_ff.index, out_ff.value};
   assign rsp_tuser = {out_ff.err, out_ff.code};
   assign rsp_tlast = out_ff.last;
endmodule
`default_nettype wire
